@@ sv/lidar_frame_deframer_unit_defines.svh @@
// ---------------------------------------------------------------------------
// lidar frame deframer assertion macros
// shared property forms used by the deframer top level
// ---------------------------------------------------------------------------
`ifndef LIDAR_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define LIDAR_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LDF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldf assertion failed (same cycle)");

// next-cycle implication, disabled in reset
`define LDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldf assertion failed (next cycle)");

`endif

@@ sv/ldf_pkg.sv @@
// ---------------------------------------------------------------------------
// ldf_pkg
// types and constants shared by the lidar frame deframer modules
// ---------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

   localparam logic [7:0] SYNC_BYTE          = 8'hA5;
   localparam logic [7:0] MAX_ERRORS_RESET   = 8'd10;
   localparam int         FRAME_SLOTS_DEFAULT = 8;
   localparam int         QUEUE_DEPTH        = 4;
   localparam int         TDATA_W            = 72;

   typedef enum logic [2:0] {
      PH_SYNC  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_CMD   = 3'd2,
      PH_SIZE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_FRAME_END  = 2'd1,
      KIND_SYNC_ERROR = 2'd2
   } kind_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [3:0]  pad;
      logic [7:0]  error_count;
      logic [2:0]  frame_slot;
      logic        checksum_ok;
      logic [15:0] frame_size;
      logic [7:0]  frame_command;
      logic [7:0]  frame_address;
      logic [15:0] payload_index;
      logic [7:0]  payload_byte;
   } tdata_type;

   typedef struct packed {
      kind_type  kind;
      tdata_type data;
   } result_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ sv/ldf_front.sv @@
// ---------------------------------------------------------------------------
// ldf_front
// byte parser: tracks the packet phase and builds a result record for each payload, check or header-error beat
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_front #(
   parameter int FRAME_SLOTS = ldf_pkg::FRAME_SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_ready,
   input  wire logic [7:0]               in_byte,
   input  wire logic [7:0]               max_errors,
   input  wire ldf_pkg::queue_status_type q_status,
   output      logic                     push,
   output      ldf_pkg::result_type      push_data
);

   localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_SLOTS - 1);

   ldf_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         sync_ff, sync_in;
   logic               high_ff, high_in;
   logic [15:0]        idx_ff, idx_in;
   logic [7:0]         addr_ff, addr_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [15:0]        size_ff, size_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         err_ff, err_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               accept;
   logic               emit;
   logic [7:0]         err_inc;
   logic [15:0]        size_full;
   logic [SLOT_W+2:0]  slot_ext;

   assign in_ready  = q_status.not_full;
   assign accept    = in_valid && in_ready;
   assign push      = accept && emit;
   assign err_inc   = err_ff + 8'd1;
   assign size_full = {in_byte, size_ff[7:0]};
   assign slot_ext  = {3'b000, slot_ff};

   always_comb begin
      phase_in  = phase_ff;
      sync_in   = sync_ff;
      high_in   = high_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      cmd_in    = cmd_ff;
      size_in   = size_ff;
      xor_in    = xor_ff;
      err_in    = err_ff;
      slot_in   = slot_ff;
      emit      = 1'b0;
      push_data = '0;
      push_data.data.frame_address = addr_ff;
      push_data.data.frame_command = cmd_ff;
      push_data.data.frame_size    = size_ff;
      push_data.data.error_count   = err_ff;
      unique case (phase_ff)
         ldf_pkg::PH_SYNC: begin
            if (in_byte == ldf_pkg::SYNC_BYTE) begin
               if (sync_ff == 2'd3) begin
                  sync_in  = 2'd0;
                  phase_in = ldf_pkg::PH_ADDR;
               end else begin
                  sync_in = sync_ff + 2'd1;
               end
            end else begin
               err_in = (err_inc > max_errors) ? 8'd0 : err_inc;
               emit   = 1'b1;
               push_data                   = '0;
               push_data.kind              = ldf_pkg::KIND_SYNC_ERROR;
               push_data.data.error_count  = err_in;
            end
         end
         ldf_pkg::PH_ADDR: begin
            addr_in  = in_byte;
            xor_in   = in_byte;
            phase_in = ldf_pkg::PH_CMD;
         end
         ldf_pkg::PH_CMD: begin
            cmd_in   = in_byte;
            xor_in   = xor_ff ^ in_byte;
            high_in  = 1'b0;
            idx_in   = 16'd0;
            phase_in = ldf_pkg::PH_SIZE;
         end
         ldf_pkg::PH_SIZE: begin
            xor_in = xor_ff ^ in_byte;
            if (!high_ff) begin
               size_in = {8'd0, in_byte};
               high_in = 1'b1;
            end else begin
               size_in  = size_full;
               high_in  = 1'b0;
               idx_in   = 16'd0;
               phase_in = (size_full == 16'd0) ? ldf_pkg::PH_CHECK : ldf_pkg::PH_DATA;
            end
         end
         ldf_pkg::PH_DATA: begin
            xor_in = xor_ff ^ in_byte;
            if (({1'b0, idx_ff} + 17'd1) >= {1'b0, size_ff}) begin
               idx_in   = 16'd0;
               phase_in = ldf_pkg::PH_CHECK;
            end else begin
               idx_in = idx_ff + 16'd1;
            end
            emit                        = 1'b1;
            push_data.kind              = ldf_pkg::KIND_PAYLOAD;
            push_data.data.payload_byte  = in_byte;
            push_data.data.payload_index = idx_ff;
         end
         ldf_pkg::PH_CHECK: begin
            slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            phase_in = ldf_pkg::PH_SYNC;
            emit     = 1'b1;
            push_data.kind             = ldf_pkg::KIND_FRAME_END;
            push_data.data.checksum_ok = (in_byte == xor_ff);
            push_data.data.frame_slot  = slot_ext[2:0];
         end
         default: begin
            phase_in = ldf_pkg::PH_SYNC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ldf_pkg::PH_SYNC;
         sync_ff  <= '0;
         high_ff  <= 1'b0;
         idx_ff   <= '0;
         addr_ff  <= '0;
         cmd_ff   <= '0;
         size_ff  <= '0;
         xor_ff   <= '0;
         err_ff   <= '0;
         slot_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         sync_ff  <= sync_in;
         high_ff  <= high_in;
         idx_ff   <= idx_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         size_ff  <= size_in;
         xor_ff   <= xor_in;
         err_ff   <= err_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ldf_queue.sv @@
// ---------------------------------------------------------------------------
// ldf_queue
// short result queue between parser and output stage
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ldf_pkg::result_type       push_data,
   input  wire logic                      pop,
   output      ldf_pkg::result_type       pop_data,
   output      ldf_pkg::queue_status_type status
);

   localparam int DEPTH = ldf_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ldf_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   assign status.not_full  = (cnt_ff != CNT_FULL);
   assign status.not_empty = (cnt_ff != '0);
   assign pop_data         = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ldf_back.sv @@
// ---------------------------------------------------------------------------
// ldf_back
// output register: drains the result queue onto the result stream
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ldf_pkg::queue_status_type q_status,
   input  wire ldf_pkg::result_type       q_data,
   output      logic                      pop,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      ldf_pkg::result_type       out_data
);

   logic                valid_ff, valid_in;
   ldf_pkg::result_type data_ff;

   assign pop       = q_status.not_empty && (!valid_ff || out_ready);
   assign valid_in  = q_status.not_empty || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= q_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/lidar_frame_deframer_unit.sv @@
// ---------------------------------------------------------------------------
// lidar_frame_deframer_unit
// deframes sync-headed, length-prefixed sensor packets from a byte stream
// ---------------------------------------------------------------------------
// One received byte is taken per clock while the result queue has room. The
// parser updates its phase in the cycle the byte is accepted and writes any
// result into a four-entry queue; the output register then takes it from the
// queue onto the result stream. req_tready drops only while that queue is
// full, so the byte rate is one per cycle for as long as results are taken
// one per cycle. max_errors is written through the csr channel, which is
// always ready; write it while no bytes are in flight.
`default_nettype none

`include "lidar_frame_deframer_unit_defines.svh"

module lidar_frame_deframer_unit #(
   parameter int FRAME_SLOTS = ldf_pkg::FRAME_SLOTS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [7:0]                 req_tdata,  // [7:0] rx_byte
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_address,
   // [39:32] frame_command, [55:40] frame_size, [56] checksum_ok,
   // [59:57] frame_slot, [67:60] error_count, [71:68] zero
   output      logic [ldf_pkg::TDATA_W-1:0] rsp_tdata,
   output      logic [1:0]                 rsp_tuser,  // [1:0] kind
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [7:0]                 csr_data    // [7:0] max_errors
);

   logic [7:0]                max_errors_ff;
   ldf_pkg::queue_status_type q_status;
   ldf_pkg::result_type       push_data;
   ldf_pkg::result_type       q_data;
   ldf_pkg::result_type       out_data;
   logic                      push;
   logic                      pop;
   logic                      out_not_summary;
   logic                      out_is_error;
   logic                      summary_bits_clear;
   logic                      frame_bits_clear;

   assign csr_ready = 1'b1;
   assign rsp_tdata = out_data.data;
   assign rsp_tuser = out_data.kind;

   assign out_not_summary    = rsp_tvalid && (out_data.kind != ldf_pkg::KIND_FRAME_END);
   assign out_is_error       = rsp_tvalid && (out_data.kind == ldf_pkg::KIND_SYNC_ERROR);
   assign summary_bits_clear = (out_data.data.checksum_ok == 1'b0) &&
                               (out_data.data.frame_slot == 3'd0);
   assign frame_bits_clear   = (out_data.data.frame_address == 8'd0) &&
                               (out_data.data.frame_size == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff <= ldf_pkg::MAX_ERRORS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_errors_ff <= csr_data;
      end
   end

   ldf_front #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .max_errors (max_errors_ff),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   ldf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   ldf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   `LDF_ASSERT_IMP(a_no_overflow, clock, reset, push, q_status.not_full)
   `LDF_ASSERT_NEXT(a_push_lands, clock, reset, push, q_status.not_empty)
   `LDF_ASSERT_IMP(a_summary_only, clock, reset, out_not_summary, summary_bits_clear)
   `LDF_ASSERT_IMP(a_error_bare, clock, reset, out_is_error, frame_bits_clear)

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// tb: lidar frame deframer testbench
// drives a byte stream of sync-headed frames, header noise and broken frames
// into the deframer, predicts every result beat from a behavioral copy of
// the parser and checks each beat field by field under random stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_PAUSE  = 8;
   localparam int PRINT_CAP   = 40;

   localparam int RX_READY   = 0;
   localparam int RX_RANDOM  = 1;
   localparam int RX_PATTERN = 2;
   localparam int RX_HEAVY   = 3;

   localparam int TX_STREAM = 0;
   localparam int TX_BURSTY = 1;

   typedef struct packed {
      ldf_pkg::kind_type kind;
      logic [7:0]        pay_byte;
      logic [15:0]       pay_index;
      logic [7:0]        address;
      logic [7:0]        command;
      logic [15:0]       frm_size;
      logic              ck_ok;
      logic [2:0]        slot;
      logic [7:0]        err_cnt;
   } deframe_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [ldf_pkg::TDATA_W-1:0]  rsp_tdata;
   logic [1:0]                   rsp_tuser;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [7:0]                   csr_data = '0;

   // parser shadow state
   logic [7:0]         err_limit = ldf_pkg::MAX_ERRORS_RESET;
   ldf_pkg::phase_type parse_ph = ldf_pkg::PH_SYNC;
   logic [1:0]         sync_seen = '0;
   logic               size_hi_next = 1'b0;
   logic [15:0]        pay_pos = '0;
   logic [7:0]         frm_addr = '0;
   logic [7:0]         frm_cmd = '0;
   logic [15:0]        frm_len = '0;
   logic [7:0]         frm_xor = '0;
   logic [7:0]         hdr_errs = '0;
   int                 slot_ctr = 0;

   logic [7:0]         unsent_bytes[$];
   deframe_result_type awaited_results[$];

   int          fail_count = 0;
   int          beats_seen = 0;
   int          bytes_queued = 0;
   int          gen_sync_cnt = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          tx_mode = TX_STREAM;
   int          rx_mode = RX_READY;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   logic [7:0]  stall_mask = 8'b0100_1101;
   ldf_pkg::tdata_type got_fields;
   deframe_result_type want_res;

   lidar_frame_deframer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   task automatic flag_error(string msg);
      if (fail_count < PRINT_CAP) begin
         $display("tb: mismatch at %0t: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic cmp_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
         flag_error($sformatf("beat %0d %s got 0x%0h want 0x%0h", beats_seen, name, got, want));
      end
   endtask

   function automatic void deframe_byte(logic [7:0] b);
      deframe_result_type r;
      logic emit;
      r = '0;
      emit = 1'b0;
      case (parse_ph)
         ldf_pkg::PH_SYNC: begin
            if (b == ldf_pkg::SYNC_BYTE) begin
               if (sync_seen == 2'd3) begin
                  sync_seen = '0;
                  parse_ph = ldf_pkg::PH_ADDR;
               end else begin
                  sync_seen = sync_seen + 2'd1;
               end
            end else begin
               // 8 bit wrap happens before the limit compare
               hdr_errs = hdr_errs + 8'd1;
               if (hdr_errs > err_limit) hdr_errs = '0;
               r.kind = ldf_pkg::KIND_SYNC_ERROR;
               emit = 1'b1;
            end
         end
         ldf_pkg::PH_ADDR: begin
            frm_addr = b;
            frm_xor = b;
            parse_ph = ldf_pkg::PH_CMD;
         end
         ldf_pkg::PH_CMD: begin
            frm_cmd = b;
            frm_xor ^= b;
            size_hi_next = 1'b0;
            pay_pos = '0;
            parse_ph = ldf_pkg::PH_SIZE;
         end
         ldf_pkg::PH_SIZE: begin
            frm_xor ^= b;
            if (!size_hi_next) begin
               frm_len = {8'h00, b};
               size_hi_next = 1'b1;
            end else begin
               frm_len[15:8] = b;
               size_hi_next = 1'b0;
               pay_pos = '0;
               parse_ph = (frm_len == 16'd0) ? ldf_pkg::PH_CHECK : ldf_pkg::PH_DATA;
            end
         end
         ldf_pkg::PH_DATA: begin
            r.kind = ldf_pkg::KIND_PAYLOAD;
            r.pay_byte = b;
            r.pay_index = pay_pos;
            r.address = frm_addr;
            r.command = frm_cmd;
            r.frm_size = frm_len;
            frm_xor ^= b;
            if (32'(pay_pos) + 1 >= 32'(frm_len)) begin
               pay_pos = '0;
               parse_ph = ldf_pkg::PH_CHECK;
            end else begin
               pay_pos = pay_pos + 16'd1;
            end
            emit = 1'b1;
         end
         ldf_pkg::PH_CHECK: begin
            r.kind = ldf_pkg::KIND_FRAME_END;
            r.address = frm_addr;
            r.command = frm_cmd;
            r.frm_size = frm_len;
            r.ck_ok = (b == frm_xor);
            r.slot = slot_ctr[2:0];
            slot_ctr = (slot_ctr + 1 >= ldf_pkg::FRAME_SLOTS_DEFAULT) ? 0 : slot_ctr + 1;
            parse_ph = ldf_pkg::PH_SYNC;
            emit = 1'b1;
         end
         default: begin
            parse_ph = ldf_pkg::PH_SYNC;
         end
      endcase
      if (emit) begin
         r.err_cnt = hdr_errs;
         awaited_results.push_back(r);
      end
   endfunction

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            void'(unsent_bytes.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat
         end else if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (unsent_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= unsent_bytes[0];
            if (tx_mode == TX_BURSTY) begin
               if (burst_left == 0) burst_left = $urandom_range(1, 16);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(1, 4);
            end
         end
      end
   end

   // result receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         stall_mask <= {stall_mask[0], stall_mask[7:1]};
         case (rx_mode)
            RX_READY:   rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= !stall_mask[0];
            default:    rsp_tready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_fields = ldf_pkg::tdata_type'(rsp_tdata);
         if (awaited_results.size() == 0) begin
            flag_error($sformatf("unexpected beat kind %0d", rsp_tuser));
         end else begin
            want_res = awaited_results.pop_front();
            cmp_field("kind", rsp_tuser, want_res.kind);
            cmp_field("payload_byte", got_fields.payload_byte, want_res.pay_byte);
            cmp_field("payload_index", got_fields.payload_index, want_res.pay_index);
            cmp_field("frame_address", got_fields.frame_address, want_res.address);
            cmp_field("frame_command", got_fields.frame_command, want_res.command);
            cmp_field("frame_size", got_fields.frame_size, want_res.frm_size);
            cmp_field("checksum_ok", got_fields.checksum_ok, want_res.ck_ok);
            cmp_field("frame_slot", got_fields.frame_slot, want_res.slot);
            cmp_field("error_count", got_fields.error_count, want_res.err_cnt);
         end
         beats_seen++;
      end
   end

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == ldf_pkg::SYNC_BYTE);
      return b;
   endfunction

   task automatic queue_byte(logic [7:0] b);
      unsent_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_noise(int n);
      repeat (n) queue_byte(noise_byte());
   endtask

   // sync bytes short of a full header, with header errors mixed in
   task automatic queue_sync_part();
      int k;
      k = $urandom_range(0, 3 - gen_sync_cnt);
      repeat (k) begin
         if ($urandom_range(0, 1) == 0) queue_byte(noise_byte());
         queue_byte(ldf_pkg::SYNC_BYTE);
         gen_sync_cnt++;
      end
      queue_noise($urandom_range(1, 3));
   endtask

   task automatic queue_frame(logic [7:0] addr, logic [7:0] cmd, logic [15:0] len,
                              bit bad_ck, bit noisy_sync);
      logic [7:0] ck;
      logic [7:0] b;
      while (gen_sync_cnt < 4) begin
         if (noisy_sync && $urandom_range(0, 3) == 0) queue_byte(noise_byte());
         queue_byte(ldf_pkg::SYNC_BYTE);
         gen_sync_cnt++;
      end
      gen_sync_cnt = 0;
      ck = addr ^ cmd ^ len[7:0] ^ len[15:8];
      queue_byte(addr);
      queue_byte(cmd);
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      for (int i = 0; i < int'(len); i++) begin
         b = 8'($urandom);
         ck ^= b;
         queue_byte(b);
      end
      if (bad_ck) ck ^= 8'h01 << $urandom_range(0, 7);
      queue_byte(ck);
   endtask

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 8));
      if (r < 95) return 16'($urandom_range(9, 40));
      return 16'($urandom_range(41, 300));
   endfunction

   task automatic write_err_limit(logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      err_limit = v;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (unsent_bytes.size() != 0 || awaited_results.size() != 0);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   initial begin
      int chunk_end;
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty frame, header errors between sync beats, bad checksum
      write_err_limit(8'd3);
      tx_mode = TX_BURSTY;
      rx_mode = RX_RANDOM;
      unsent_bytes = {ldf_pkg::SYNC_BYTE, ldf_pkg::SYNC_BYTE, ldf_pkg::SYNC_BYTE,
                      ldf_pkg::SYNC_BYTE, 8'h00, 8'hFF, 8'h00, 8'h00,
                      8'hFF, 8'h00, 8'hFF, ldf_pkg::SYNC_BYTE, ldf_pkg::SYNC_BYTE, 8'h5A,
                      ldf_pkg::SYNC_BYTE, ldf_pkg::SYNC_BYTE,
                      8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h00, 8'h03, 8'h7F, 8'h80};
      bytes_queued += unsent_bytes.size();
      wait_idle();

      write_err_limit(8'd0);
      rx_mode = RX_PATTERN;
      queue_noise(12);
      repeat (3) queue_frame(8'($urandom), 8'($urandom), pick_len(), 1'b0, 1'b1);
      wait_idle();

      // counter runs through 255 and wraps within 8 bits, under a long receiver hold
      write_err_limit(8'd255);
      tx_mode = TX_STREAM;
      rx_mode = RX_READY;
      holds_asked++;
      queue_noise(260);
      queue_frame(8'($urandom), 8'($urandom), 16'd1, 1'b0, 1'b0);
      wait_idle();

      for (int chunk = 0; chunk < 2; chunk++) begin
         write_err_limit(chunk == 1 ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 12)));
         tx_mode = (chunk == 0) ? TX_STREAM : $urandom_range(TX_STREAM, TX_BURSTY);
         rx_mode = (chunk == 0) ? RX_READY : $urandom_range(RX_READY, RX_HEAVY);
         if (chunk == 1) holds_asked++;
         chunk_end = bytes_queued + 60;
         while (bytes_queued < chunk_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               queue_frame(8'($urandom), 8'($urandom), pick_len(),
                           $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
            end else if (pick == 7) begin
               queue_noise($urandom_range(1, 5));
            end else if (pick == 8) begin
               queue_sync_part();
            end else begin
               // trailing junk after a complete frame
               queue_frame(8'($urandom), 8'($urandom), pick_len(), 1'b0, 1'b0);
               queue_noise($urandom_range(1, 3));
            end
         end
         wait_idle();
      end

      repeat (2 * IDLE_PAUSE) @(posedge clock);
      if (awaited_results.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", awaited_results.size()));
      end
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
